// ----- src/mct_pkg.sv -----
package mct_pkg;

    // field widths
    localparam int PRICE_W  = 32;
    localparam int LIMIT_W  = 10;
    localparam int POS_W    = 11;
    localparam int ACT_W    = 2;
    localparam int EMA_W    = 48;
    localparam int CASH_W   = 56;

    // ema difference: clamped to +-2^40, split in two halves for the multiplier
    localparam int DIFF_LIMIT_EXP = 40;
    localparam int DIFF_W         = DIFF_LIMIT_EXP + 2;
    localparam int DIFF_LO_W      = DIFF_W / 2;

    localparam int ALPHA_FRAC_BITS_DEF = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);

    typedef enum logic [ACT_W-1:0] {
        ACT_HOLD = 2'd0,
        ACT_BUY  = 2'd1,
        ACT_SELL = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        SEL_SHORT,
        SEL_LONG,
        SEL_SIG
    } t_ema_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_DIFF,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_UPDATE,
        ST_MACD,
        ST_TRADE,
        ST_VAL_MUL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic     load;
        logic     seed;
        logic     diff;
        logic     mul_lo;
        logic     mul_hi;
        logic     update;
        logic     macd;
        logic     trade;
        logic     val_mul;
        logic     emit;
        t_ema_sel sel;
    } t_cmd;

endpackage

// ----- src/mct_in_if.sv -----
interface mct_in_if;
    logic                        valid;
    logic                        ready;
    logic [mct_pkg::PRICE_W-1:0] close_price;
    logic                        in_window;
    logic                        seed_day;
    logic                        last_day;

    modport source (output valid, close_price, in_window, seed_day, last_day, input ready);
    modport sink   (input valid, close_price, in_window, seed_day, last_day, output ready);
endinterface

// ----- src/mct_out_if.sv -----
interface mct_out_if;
    logic                              valid;
    logic                              ready;
    logic [mct_pkg::ACT_W-1:0]         action;
    logic signed [mct_pkg::POS_W-1:0]  position;
    logic signed [mct_pkg::EMA_W-1:0]  macd_value;
    logic signed [mct_pkg::EMA_W-1:0]  signal_value;
    logic signed [mct_pkg::CASH_W-1:0] cash;
    logic signed [mct_pkg::CASH_W-1:0] final_value;
    logic                              is_last;

    modport source (output valid, action, position, macd_value, signal_value, cash,
                    final_value, is_last, input ready);
    modport sink   (input valid, action, position, macd_value, signal_value, cash,
                    final_value, is_last, output ready);
endinterface

// ----- src/mct_ctrl.sv -----
module mct_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_window,
    input  logic          i_seed_day,
    input  logic          i_last_day,
    input  logic          i_out_ready,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output mct_pkg::t_cmd o_cmd
);

    mct_pkg::t_state   r_state, n_state;
    mct_pkg::t_ema_sel r_sel, n_sel;
    logic              r_update, n_update;
    logic              r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mct_pkg::ST_IDLE;
            r_sel       <= mct_pkg::SEL_SHORT;
            r_update    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sel    <= n_sel;
            r_update <= n_update;
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        n_update   = r_update;
        o_cmd      = '0;
        o_cmd.sel  = r_sel;
        o_in_ready = 1'b0;
        unique case (r_state)
            mct_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_sel      = mct_pkg::SEL_SHORT;
                    n_update   = i_in_window && !i_seed_day;
                    if (i_in_window && i_seed_day) begin
                        n_state = mct_pkg::ST_SEED;
                    end else if (i_in_window) begin
                        n_state = mct_pkg::ST_DIFF;
                    end else if (i_last_day) begin
                        n_state = mct_pkg::ST_MACD;
                    end
                end
            end
            mct_pkg::ST_SEED: begin
                o_cmd.seed = 1'b1;
                n_state    = mct_pkg::ST_MACD;
            end
            mct_pkg::ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = mct_pkg::ST_MUL_LO;
            end
            mct_pkg::ST_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = mct_pkg::ST_MUL_HI;
            end
            mct_pkg::ST_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = mct_pkg::ST_UPDATE;
            end
            mct_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
                case (r_sel)
                    mct_pkg::SEL_SHORT: begin
                        n_sel   = mct_pkg::SEL_LONG;
                        n_state = mct_pkg::ST_DIFF;
                    end
                    mct_pkg::SEL_LONG: begin
                        n_state = mct_pkg::ST_MACD;
                    end
                    default: begin
                        n_state = mct_pkg::ST_TRADE;
                    end
                endcase
            end
            mct_pkg::ST_MACD: begin
                o_cmd.macd = 1'b1;
                if (r_update) begin
                    n_sel   = mct_pkg::SEL_SIG;
                    n_state = mct_pkg::ST_DIFF;
                end else begin
                    n_state = mct_pkg::ST_VAL_MUL;
                end
            end
            mct_pkg::ST_TRADE: begin
                o_cmd.trade = 1'b1;
                n_state     = mct_pkg::ST_VAL_MUL;
            end
            mct_pkg::ST_VAL_MUL: begin
                o_cmd.val_mul = 1'b1;
                n_state       = mct_pkg::ST_EMIT;
            end
            mct_pkg::ST_EMIT: begin
                // wait for the output register to drain
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = mct_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mct_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    // a word that gives no result returns straight to idle
    a_no_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid && !i_in_window && !i_last_day)
            |=> r_state == mct_pkg::ST_IDLE)
        else $error("no-result word did not return to idle");

    // trading only happens on an in-window update day, after the signal ema
    a_trade_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mct_pkg::ST_TRADE) |-> (r_update && r_sel == mct_pkg::SEL_SIG))
        else $error("trade step outside an update run");

    // a result loaded into the output register is presented next cycle
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_out_valid && r_state == mct_pkg::ST_IDLE))
        else $error("emitted result not presented");

endmodule

// ----- src/mct_datapath.sv -----
module mct_datapath #(
    parameter int ALPHA_FRAC_BITS = mct_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mct_pkg::t_cmd                     i_cmd,
    input  logic                              i_cfg_we,
    input  logic [mct_pkg::LIMIT_W-1:0]       i_cfg_data,
    input  logic [mct_pkg::PRICE_W-1:0]       i_close_price,
    input  logic                              i_in_window,
    input  logic                              i_seed_day,
    input  logic                              i_last_day,
    output logic [mct_pkg::ACT_W-1:0]         o_action,
    output logic signed [mct_pkg::POS_W-1:0]  o_position,
    output logic signed [mct_pkg::EMA_W-1:0]  o_macd_value,
    output logic signed [mct_pkg::EMA_W-1:0]  o_signal_value,
    output logic signed [mct_pkg::CASH_W-1:0] o_cash,
    output logic signed [mct_pkg::CASH_W-1:0] o_final_value,
    output logic                              o_is_last
);

    localparam int AW      = ALPHA_FRAC_BITS;
    localparam int ALPHA_W = AW + 1;
    localparam longint ALPHA_SHORT = ((longint'(1) << (AW + 2)) + 13) / 26;
    localparam longint ALPHA_LONG  = ((longint'(1) << (AW + 2)) + 27) / 54;
    localparam longint ALPHA_SIG   = ((longint'(1) << (AW + 2)) + 10) / 20;

    localparam int EMA_W  = mct_pkg::EMA_W;
    localparam int MACD_W = EMA_W + 1;
    localparam int SUM_W  = EMA_W + 2;
    localparam int DIFF_W = mct_pkg::DIFF_W;
    localparam int LO_W   = mct_pkg::DIFF_LO_W;
    localparam int OPND_W = LO_W + 1;
    localparam int PROD_W = OPND_W + ALPHA_W;
    localparam int ACC_W  = DIFF_W + ALPHA_W;
    localparam int STEP_W = ACC_W - AW;
    localparam int CASH_W = mct_pkg::CASH_W;
    localparam int CSUM_W = CASH_W + 1;
    localparam int POS_W  = mct_pkg::POS_W;
    localparam int VAL_W  = POS_W + mct_pkg::PRICE_W + 1;

    localparam logic signed [SUM_W-1:0] DIFF_MAX =
        SUM_W'(longint'(1) << mct_pkg::DIFF_LIMIT_EXP);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(longint'(1) << (AW - 1));
    localparam logic signed [EMA_W-1:0] EMA_MAX = {1'b0, {(EMA_W - 1){1'b1}}};
    localparam logic signed [EMA_W-1:0] EMA_MIN = {1'b1, {(EMA_W - 1){1'b0}}};
    localparam logic signed [CASH_W-1:0] CASH_MAX = {1'b0, {(CASH_W - 1){1'b1}}};
    localparam logic signed [CASH_W-1:0] CASH_MIN = {1'b1, {(CASH_W - 1){1'b0}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W - 1){1'b0}}};

    function automatic logic signed [EMA_W-1:0] sat_ema(input logic signed [SUM_W-1:0] v);
        logic signed [EMA_W-1:0] res;
        if (v[SUM_W-1:EMA_W-1] == '0 || v[SUM_W-1:EMA_W-1] == '1) begin
            res = v[EMA_W-1:0];
        end else if (v[SUM_W-1]) begin
            res = EMA_MIN;
        end else begin
            res = EMA_MAX;
        end
        return res;
    endfunction

    function automatic logic signed [CASH_W-1:0] sat_cash(input logic signed [CSUM_W-1:0] v);
        logic signed [CASH_W-1:0] res;
        if (v[CSUM_W-1] == v[CASH_W-1]) begin
            res = v[CASH_W-1:0];
        end else if (v[CSUM_W-1]) begin
            res = CASH_MIN;
        end else begin
            res = CASH_MAX;
        end
        return res;
    endfunction

    // architectural state
    logic signed [EMA_W-1:0]         r_short, r_long, r_sig;
    logic signed [POS_W-1:0]         r_pos;
    logic signed [CASH_W-1:0]        r_cash;
    logic [mct_pkg::PRICE_W-1:0]     r_last_price;
    logic [mct_pkg::LIMIT_W-1:0]     r_max_pos;

    // working registers
    logic [mct_pkg::PRICE_W-1:0]     r_price;
    logic                            r_last;
    mct_pkg::t_action                r_action;
    logic signed [DIFF_W-1:0]        r_diff;
    logic signed [ACC_W-1:0]         r_acc;
    logic signed [MACD_W-1:0]        r_macd;
    logic signed [VAL_W-1:0]         r_prod;

    // output register
    logic [mct_pkg::ACT_W-1:0]       r_out_action;
    logic signed [POS_W-1:0]         r_out_pos;
    logic signed [EMA_W-1:0]         r_out_macd, r_out_sig;
    logic signed [CASH_W-1:0]        r_out_cash, r_out_final;
    logic                            r_out_last;

    logic signed [EMA_W-1:0]   ema_cur;
    logic signed [ALPHA_W-1:0] alpha;
    logic signed [SUM_W-1:0]   diff_x, diff_full;
    logic signed [DIFF_W-1:0]  diff_clamped;
    logic signed [OPND_W-1:0]  mul_a;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [STEP_W-1:0]  ema_step;
    logic signed [EMA_W-1:0]   ema_new;
    logic signed [MACD_W-1:0]  sig_ext;
    logic signed [POS_W-1:0]   limit;
    logic                      do_buy, do_sell;
    logic signed [CSUM_W-1:0]  price_term;
    logic signed [CASH_W-1:0]  cash_traded;
    logic signed [CASH_W-1:0]  final_sat;

    always_comb begin
        case (i_cmd.sel)
            mct_pkg::SEL_SHORT: begin
                ema_cur = r_short;
                alpha   = ALPHA_W'(ALPHA_SHORT);
            end
            mct_pkg::SEL_LONG: begin
                ema_cur = r_long;
                alpha   = ALPHA_W'(ALPHA_LONG);
            end
            default: begin
                ema_cur = r_sig;
                alpha   = ALPHA_W'(ALPHA_SIG);
            end
        endcase
    end

    // x - e, clamped before the multiply
    always_comb begin
        if (i_cmd.sel == mct_pkg::SEL_SIG) begin
            diff_x = SUM_W'(r_macd);
        end else begin
            diff_x = SUM_W'({1'b0, r_price});
        end
        diff_full = diff_x - SUM_W'(ema_cur);
        if (diff_full > DIFF_MAX) begin
            diff_clamped = DIFF_W'(DIFF_MAX);
        end else if (diff_full < -DIFF_MAX) begin
            diff_clamped = DIFF_W'(-DIFF_MAX);
        end else begin
            diff_clamped = DIFF_W'(diff_full);
        end
    end

    // shared multiplier: low half unsigned, then high half signed
    assign mul_a = i_cmd.mul_hi ? OPND_W'($signed(r_diff[DIFF_W-1:LO_W]))
                                : $signed({1'b0, r_diff[LO_W-1:0]});
    assign mul_p = mul_a * alpha;

    // floor shift of the rounded product, then saturate
    assign ema_step = STEP_W'(r_acc >>> AW);
    assign ema_new  = sat_ema(SUM_W'(ema_cur) + SUM_W'(ema_step));

    assign sig_ext = MACD_W'(r_sig);
    assign limit   = $signed({1'b0, r_max_pos});
    assign do_buy  = (r_macd > sig_ext) && (r_pos < limit);
    assign do_sell = (r_macd < sig_ext) && (r_pos > -limit);

    assign price_term  = do_buy ? -CSUM_W'({1'b0, r_price}) : CSUM_W'({1'b0, r_price});
    assign cash_traded = sat_cash(CSUM_W'(r_cash) + price_term);
    assign final_sat   = sat_cash(CSUM_W'(r_cash) + CSUM_W'(r_prod));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short      <= '0;
            r_long       <= '0;
            r_sig        <= '0;
            r_pos        <= '0;
            r_cash       <= '0;
            r_last_price <= '0;
            r_max_pos    <= mct_pkg::LIMIT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_max_pos <= i_cfg_data;
            end
            if (i_cmd.load && i_in_window && !i_seed_day) begin
                r_last_price <= i_close_price;
            end
            if (i_cmd.seed) begin
                r_short <= $signed(EMA_W'(r_price));
                r_long  <= $signed(EMA_W'(r_price));
                r_sig   <= '0;
            end
            if (i_cmd.update) begin
                case (i_cmd.sel)
                    mct_pkg::SEL_SHORT: r_short <= ema_new;
                    mct_pkg::SEL_LONG:  r_long  <= ema_new;
                    default:            r_sig   <= ema_new;
                endcase
            end
            if (i_cmd.trade && (do_buy || do_sell)) begin
                r_cash <= cash_traded;
                r_pos  <= do_buy ? r_pos + POS_W'(1) : r_pos - POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_price  <= i_close_price;
            r_last   <= i_last_day;
            r_action <= mct_pkg::ACT_HOLD;
        end
        if (i_cmd.diff) begin
            r_diff <= diff_clamped;
        end
        if (i_cmd.mul_lo) begin
            r_acc <= ACC_W'(mul_p) + ROUND_HALF;
        end else if (i_cmd.mul_hi) begin
            r_acc <= r_acc + (ACC_W'(mul_p) <<< LO_W);
        end
        if (i_cmd.macd) begin
            r_macd <= MACD_W'(r_short) - MACD_W'(r_long);
        end
        if (i_cmd.trade) begin
            if (do_buy) begin
                r_action <= mct_pkg::ACT_BUY;
            end else if (do_sell) begin
                r_action <= mct_pkg::ACT_SELL;
            end
        end
        if (i_cmd.val_mul) begin
            r_prod <= r_pos * $signed({1'b0, r_last_price});
        end
        if (i_cmd.emit) begin
            r_out_action <= r_action;
            r_out_pos    <= r_pos;
            r_out_macd   <= $signed(r_macd[EMA_W-1:0]);
            r_out_sig    <= r_sig;
            r_out_cash   <= r_cash;
            r_out_final  <= r_last ? final_sat : '0;
            r_out_last   <= r_last;
        end
    end

    assign o_action       = r_out_action;
    assign o_position     = r_out_pos;
    assign o_macd_value   = r_out_macd;
    assign o_signal_value = r_out_sig;
    assign o_cash         = r_out_cash;
    assign o_final_value  = r_out_final;
    assign o_is_last      = r_out_last;

    // position stays inside the 10-bit limit range
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos != POS_MIN)
        else $error("position left its range");

    // a seed leaves both emas equal and the signal cleared
    a_seed_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.seed |=> (r_short == r_long && r_sig == '0))
        else $error("seed did not set the emas");

endmodule

// ----- src/macd_crossover_trader.sv -----
// MACD 12/26/9 crossover trader. Each input word is one daily close (unsigned
// fixed point). A seed day sets both EMAs to the price, clears the signal EMA
// and answers hold; every later in-window day updates the 12- and 26-period
// EMAs, forms MACD = short - long, updates its 9-period signal EMA and trades
// one share: buy when MACD is above the signal and the position is below the
// limit, sell when it is below the signal and the position is above minus the
// limit. Cash moves by the price and saturates at 56 bits. A day flagged last
// also carries cash + position * last price. Out-of-window days give no
// result unless flagged last, which then reports the current state as hold.
// The limit is written through i_cfg_we / i_cfg_data (reset value 1); the
// user must write it only while the block is idle; the block does not enforce
// it. One word is worked on at a time. A seed day steps through seed, MACD,
// valuation and emit, an out-of-window last day through MACD, valuation and
// emit; other out-of-window days stay idle. A trading day is paced by the
// single shared EMA multiplier: each EMA update needs a difference step, two
// multiply passes over the clamped difference halves and an update step, and
// the three EMAs go in turn. A result waits in the output register while the
// next word is accepted; only a further result waits for it to drain.
module macd_crossover_trader #(
    parameter int ALPHA_FRAC_BITS = mct_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mct_pkg::LIMIT_W-1:0] i_cfg_data,
    mct_in_if.sink                      i_in,
    mct_out_if.source                   o_out
);

    mct_pkg::t_cmd cmd;
    logic          in_ready;
    logic          out_valid;

    // sequencer: accepts a word, steps the datapath, hands off the result
    mct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_window (i_in.in_window),
        .i_seed_day  (i_in.seed_day),
        .i_last_day  (i_in.last_day),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    // emas, trade decision, cash and valuation, plus the output register
    mct_datapath #(
        .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_close_price  (i_in.close_price),
        .i_in_window    (i_in.in_window),
        .i_seed_day     (i_in.seed_day),
        .i_last_day     (i_in.last_day),
        .o_action       (o_out.action),
        .o_position     (o_out.position),
        .o_macd_value   (o_out.macd_value),
        .o_signal_value (o_out.signal_value),
        .o_cash         (o_out.cash),
        .o_final_value  (o_out.final_value),
        .o_is_last      (o_out.is_last)
    );

    // handshake outputs
    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule
